[rtl/csfr_pkg.sv]
// ----------------------------------------------------------------------------
// csfr_pkg: shared types and constants of the co2 sensor frame receiver
// Request and response payloads, function and status codes, register indexes.
// ----------------------------------------------------------------------------
package csfr_pkg;

   localparam int unsigned FUNC_W    = 2;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned PPM_W     = 16;
   localparam int unsigned SECONDS_W = 10;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_FORWARDED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SUPPRESSED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HEADER = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_SECONDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_FIRST   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_SECOND  = 2'd2;

   localparam logic [BYTE_W-1:0] HEADER_START = 8'hFF;
   localparam logic [BYTE_W-1:0] HEADER_CMD   = 8'h86;

   localparam logic [POS_W-1:0] POS_START    = 4'd0;
   localparam logic [POS_W-1:0] POS_CMD      = 4'd1;
   localparam logic [POS_W-1:0] POS_PPM_HIGH = 4'd2;
   localparam logic [POS_W-1:0] POS_PPM_LOW  = 4'd3;
   localparam logic [POS_W-1:0] POS_LAST_SUM = 4'd7;
   localparam logic [POS_W-1:0] POS_CHECK    = 4'd8;
   localparam logic [POS_W-1:0] FRAME_LEN    = 4'd9;

   localparam logic [SECONDS_W-1:0] SECONDS_MAX = 10'd1023;

   localparam logic [SECONDS_W-1:0] WARMUP_SECONDS_RESET = 10'd120;
   localparam logic [PPM_W-1:0]     WARMUP_FIRST_RESET   = 16'd429;
   localparam logic [PPM_W-1:0]     WARMUP_SECOND_RESET  = 16'd410;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PPM_W-1:0]    ppm;
      logic [BYTE_W-1:0]   expected_checksum;
   } rsp_type;

   typedef struct packed {
      logic [SECONDS_W-1:0] warmup_seconds;
      logic [PPM_W-1:0]     warmup_value_first;
      logic [PPM_W-1:0]     warmup_value_second;
   } cfg_type;

endpackage

[rtl/csfr_parser.sv]
// ----------------------------------------------------------------------------
// csfr_parser: frame state and single-pass result logic
// Tracks byte position, checksum, header and uptime; forms the result on the
// ninth byte of a frame.
// ----------------------------------------------------------------------------
module csfr_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  csfr_pkg::req_type req,
   input  csfr_pkg::cfg_type cfg,
   output logic              res_valid,
   output csfr_pkg::rsp_type res
);
   import csfr_pkg::*;

   logic [POS_W-1:0]     byte_position_ff, byte_position_in;
   logic [BYTE_W-1:0]    running_sum_ff, running_sum_in;
   logic                 header_good_ff, header_good_in;
   logic [BYTE_W-1:0]    ppm_high_ff, ppm_high_in;
   logic [BYTE_W-1:0]    ppm_low_ff, ppm_low_in;
   logic [SECONDS_W-1:0] seconds_ff, seconds_in;
   logic                 forwarding_ff, forwarding_in;

   logic [BYTE_W-1:0] expected;
   logic [PPM_W-1:0]  ppm;
   logic              warm_done;
   logic              not_bogus;

   assign expected  = BYTE_W'(8'd0 - running_sum_ff);
   assign ppm       = {ppm_high_ff, ppm_low_ff};
   assign warm_done = (seconds_ff >= cfg.warmup_seconds);
   assign not_bogus = (ppm != cfg.warmup_value_first) && (ppm != cfg.warmup_value_second);

   always_comb begin
      byte_position_in = byte_position_ff;
      running_sum_in   = running_sum_ff;
      header_good_in   = header_good_ff;
      ppm_high_in      = ppm_high_ff;
      ppm_low_in       = ppm_low_ff;
      seconds_in       = seconds_ff;
      forwarding_in    = forwarding_ff;
      res_valid        = 1'b0;
      res.ppm          = ppm;
      res.expected_checksum = expected;
      res.status       = STATUS_BAD_HEADER;

      if (accept) begin
         case (req.func)
            FUNC_TICK: begin
               if (seconds_ff < cfg.warmup_seconds && seconds_ff < SECONDS_MAX) begin
                  seconds_in = seconds_ff + 1'b1;
               end
            end
            FUNC_RESTART: begin
               byte_position_in = POS_START;
               running_sum_in   = '0;
               header_good_in   = 1'b0;
            end
            FUNC_BYTE: begin
               if (byte_position_ff < FRAME_LEN) begin
                  byte_position_in = byte_position_ff + 1'b1;
                  if (byte_position_ff == POS_START) begin
                     header_good_in = (req.rx_byte == HEADER_START);
                  end else if (byte_position_ff == POS_CMD) begin
                     header_good_in = header_good_ff && (req.rx_byte == HEADER_CMD);
                  end
                  if (byte_position_ff == POS_PPM_HIGH) begin
                     ppm_high_in = req.rx_byte;
                  end else if (byte_position_ff == POS_PPM_LOW) begin
                     ppm_low_in = req.rx_byte;
                  end
                  if (byte_position_ff >= POS_CMD && byte_position_ff <= POS_LAST_SUM) begin
                     running_sum_in = running_sum_ff + req.rx_byte;
                  end
                  if (byte_position_ff == POS_CHECK) begin
                     res_valid = 1'b1;
                     if (!header_good_ff) begin
                        res.status = STATUS_BAD_HEADER;
                     end else if (expected != req.rx_byte) begin
                        res.status = STATUS_BAD_SUM;
                     end else begin
                        forwarding_in = forwarding_ff || not_bogus || warm_done;
                        res.status = forwarding_in ? STATUS_FORWARDED : STATUS_SUPPRESSED;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= POS_START;
         running_sum_ff   <= '0;
         header_good_ff   <= 1'b0;
         seconds_ff       <= '0;
         forwarding_ff    <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         running_sum_ff   <= running_sum_in;
         header_good_ff   <= header_good_in;
         seconds_ff       <= seconds_in;
         forwarding_ff    <= forwarding_in;
      end
      ppm_high_ff <= ppm_high_in;
      ppm_low_ff  <= ppm_low_in;
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= FRAME_LEN)
      else $error("byte position beyond frame length");

   a_latch_holds: assert property (@(posedge clock) disable iff (reset)
      !$fell(forwarding_ff))
      else $error("forwarding latch cleared without reset");

   a_result_on_last: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> byte_position_ff == FRAME_LEN)
      else $error("result not at end of frame");

endmodule

[rtl/csfr_skid.sv]
// ----------------------------------------------------------------------------
// csfr_skid: response output register with skid stage
// Holds a finished response while the receiver stalls, so requests keep
// flowing until the skid stage fills.
// ----------------------------------------------------------------------------
module csfr_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  csfr_pkg::rsp_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output csfr_pkg::rsp_type out_data,
   input  logic              out_ready
);
   import csfr_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage full with empty output register");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("response written while skid stage full");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(main_valid_ff && !out_ready))
      else $error("skid stage filled without a stall");

endmodule

[rtl/co2_sensor_frame_receiver.sv]
// ----------------------------------------------------------------------------
// co2_sensor_frame_receiver: response frame receiver of a uart co2 sensor
// Checks header and checksum of the 9-byte frame, extracts ppm and gates
// readings behind a warm-up latch.
// ----------------------------------------------------------------------------
// usage
//   req channel: one request per byte, one-second tick or frame restart
//   (func); a request can be taken every cycle while req_ready is high.
//   rsp channel: one response on the ninth byte of a frame, with status,
//   ppm and expected checksum; ticks, restarts and other bytes give none.
//   csr channel: always ready; index 0 warm-up seconds, 1 and 2 the two
//   bogus warm-up ppm values. write only while no request is in flight.
//   output: the response to the ninth byte is registered before it is on rsp.
//   throughput: one request per cycle while req_ready is high, set by the
//   single-pass parser between the request port and the output register.
//   stall: a response waiting on rsp_ready sits in the output register; one
//   more fits in the skid stage, after which req_ready drops until the
//   output drains.
//   reset: synchronous; the frame restarts, uptime and latch clear and the
//   warm-up registers return to 120 s, 429 ppm and 410 ppm.
// ----------------------------------------------------------------------------
module co2_sensor_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  csfr_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output csfr_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [csfr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [csfr_pkg::CSR_DAT_W-1:0]       csr_data
);
   import csfr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    res_valid;
   rsp_type res;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WARMUP_SECONDS: cfg_in.warmup_seconds      = csr_data[SECONDS_W-1:0];
            CSR_WARMUP_FIRST:   cfg_in.warmup_value_first  = csr_data[PPM_W-1:0];
            CSR_WARMUP_SECOND:  cfg_in.warmup_value_second = csr_data[PPM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warmup_seconds      <= WARMUP_SECONDS_RESET;
         cfg_ff.warmup_value_first  <= WARMUP_FIRST_RESET;
         cfg_ff.warmup_value_second <= WARMUP_SECOND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   csfr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .out_ready (rsp_ready)
   );

endmodule
